>>> hdl/positional_array_list_engine_macros.svh
// Assertion macros for the positional array list engine.
`ifndef POSITIONAL_ARRAY_LIST_ENGINE_MACROS_SVH
`define POSITIONAL_ARRAY_LIST_ENGINE_MACROS_SVH
`ifndef SYNTH
// Condition must hold at every clock edge outside reset
`define PALE_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// Antecedent implies consequent in the same cycle
`define PALE_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define PALE_ASSERT_ALWAYS(label, clk, rst_n, cond, msg)
`define PALE_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> hdl/pale_pkg.sv
// Shared types and constants for the positional array list engine.
package pale_pkg;

    localparam int DEPTH     = 32;
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int CNT_W     = 6;
    localparam int KIND_W    = 3;
    localparam int STATUS_W  = 3;

    localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(32);

    // Operation codes carried by an input transfer
    typedef enum logic [KIND_W-1:0] {
        K_PUSH = 3'd0,
        K_POP  = 3'd1,
        K_INS  = 3'd2,
        K_DEL  = 3'd3,
        K_SWAP = 3'd4,
        K_SHOW = 3'd5
    } t_kind;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 3'd0,
        ST_OVF    = 3'd1,
        ST_UNF    = 3'd2,
        ST_BADPOS = 3'd3,
        ST_EMPTY  = 3'd4
    } t_status;

endpackage

>>> hdl/positional_array_list_engine.sv
// Positional array list engine: top level with sequencer and entry memory.
// Sequence: decode, then the memory steps of pop, swap, insert or delete, then the result;
// show streams one result per cycle while the receiver is ready.
// Throughput: one item at a time; every shift moves one entry through the
// entry memory as a read, then a write.
// Reset: synchronous, clears entry count, capacity to 32; memory is not cleared.
`include "positional_array_list_engine_macros.svh"

module positional_array_list_engine
    import pale_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // configuration
    input  logic                     i_cfg_we,
    input  logic [CNT_W-1:0]         i_cfg_wdata,
    // input channel
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [KIND_W-1:0]        i_kind,
    input  logic signed [DATA_W-1:0] i_value,
    input  logic [CNT_W-1:0]         i_position,
    input  logic [CNT_W-1:0]         i_second_position,
    // output channel
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [STATUS_W-1:0]      o_status,
    output logic signed [DATA_W-1:0] o_data,
    output logic [CNT_W-1:0]         o_entry_count,
    output logic                     o_last
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_POP,
        S_INS,
        S_INS_W,
        S_DEL_D,
        S_DEL,
        S_DEL_W,
        S_SW1,
        S_SW2,
        S_SW3,
        S_SHOW,
        S_RESP
    } t_state;

    t_state                    r_state, n_state;
    t_kind                     r_kind, n_kind;
    logic signed [DATA_W-1:0]  r_val, n_val;
    logic [CNT_W-1:0]          r_p, n_p;
    logic [CNT_W-1:0]          r_q, n_q;
    logic [CNT_W-1:0]          r_idx, n_idx;
    logic signed [DATA_W-1:0]  r_tmp, n_tmp;
    t_status                   r_st, n_st;
    logic [CNT_W-1:0]          r_fill, n_fill;
    logic [CNT_W-1:0]          r_cap;

    logic                      r_ovalid, n_ovalid;
    t_status                   r_ostatus, n_ostatus;
    logic signed [DATA_W-1:0]  r_odata, n_odata;
    logic [CNT_W-1:0]          r_ocount, n_ocount;
    logic                      r_olast, n_olast;

    logic signed [DATA_W-1:0]  r_mem [DEPTH];
    logic signed [DATA_W-1:0]  r_rdata;

    logic [ADDR_W-1:0]         rd_addr;
    logic                      mem_we;
    logic [ADDR_W-1:0]         mem_waddr;
    logic signed [DATA_W-1:0]  mem_wdata;

    logic [CNT_W-1:0]          lim;
    logic [CNT_W-1:0]          pm1, qm1;
    logic                      out_free;
    logic                      in_acc;

    assign o_in_ready    = (r_state == S_IDLE);
    assign in_acc        = i_in_valid && o_in_ready;
    assign out_free      = !r_ovalid || i_out_ready;
    assign lim           = (r_cap < CNT_W'(DEPTH)) ? r_cap : CNT_W'(DEPTH);
    assign pm1           = r_p - CNT_W'(1);
    assign qm1           = r_q - CNT_W'(1);

    assign o_out_valid   = r_ovalid;
    assign o_status      = r_ostatus;
    assign o_data        = r_odata;
    assign o_entry_count = r_ocount;
    assign o_last        = r_olast;

    // Sequencer: one memory read and at most one write per cycle
    always_comb begin
        n_state   = r_state;
        n_kind    = r_kind;
        n_val     = r_val;
        n_p       = r_p;
        n_q       = r_q;
        n_idx     = r_idx;
        n_tmp     = r_tmp;
        n_st      = r_st;
        n_fill    = r_fill;
        n_ovalid  = r_ovalid && !i_out_ready;
        n_ostatus = r_ostatus;
        n_odata   = r_odata;
        n_ocount  = r_ocount;
        n_olast   = r_olast;
        rd_addr   = r_idx[ADDR_W-1:0];
        mem_we    = 1'b0;
        mem_waddr = r_idx[ADDR_W-1:0];
        mem_wdata = r_val;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_kind = t_kind'(i_kind);
                    n_val  = i_value;
                    n_p    = i_position;
                    n_q    = i_second_position;
                    // unknown kinds are dropped without a result
                    if (i_kind <= K_SHOW) begin
                        n_state = S_DECODE;
                    end
                end
            end
            S_DECODE: begin
                n_st    = ST_OK;
                n_tmp   = '0;
                n_state = S_RESP;
                case (r_kind)
                    K_PUSH: begin
                        if (r_fill >= lim) begin
                            n_st = ST_OVF;
                        end else begin
                            mem_we    = 1'b1;
                            mem_waddr = r_fill[ADDR_W-1:0];
                            n_fill    = r_fill + CNT_W'(1);
                        end
                    end
                    K_POP: begin
                        if (r_fill == '0) begin
                            n_st = ST_UNF;
                        end else begin
                            rd_addr = ADDR_W'(r_fill - CNT_W'(1));
                            n_state = S_POP;
                        end
                    end
                    K_INS: begin
                        if (r_fill >= lim) begin
                            n_st = ST_OVF;
                        end else if (r_p == '0 || r_p > r_fill + CNT_W'(1)) begin
                            n_st = ST_BADPOS;
                        end else begin
                            n_idx   = r_fill;
                            n_state = S_INS;
                        end
                    end
                    K_DEL: begin
                        if (r_fill == '0) begin
                            n_st = ST_UNF;
                        end else if (r_p == '0 || r_p > r_fill) begin
                            n_st = ST_BADPOS;
                        end else begin
                            rd_addr = pm1[ADDR_W-1:0];
                            n_state = S_DEL_D;
                        end
                    end
                    K_SWAP: begin
                        if (r_p == '0 || r_p > r_fill || r_q == '0 || r_q > r_fill) begin
                            n_st = ST_BADPOS;
                        end else begin
                            rd_addr = pm1[ADDR_W-1:0];
                            n_state = S_SW1;
                        end
                    end
                    K_SHOW: begin
                        if (r_fill == '0) begin
                            n_st = ST_EMPTY;
                        end else begin
                            n_idx   = '0;
                            rd_addr = '0;
                            n_state = S_SHOW;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            // popped word arrives from memory
            S_POP: begin
                n_tmp   = r_rdata;
                n_fill  = r_fill - CNT_W'(1);
                n_state = S_RESP;
            end
            // insert: move entries up from the end until the target slot
            S_INS: begin
                if (r_idx == pm1) begin
                    mem_we  = 1'b1;
                    n_fill  = r_fill + CNT_W'(1);
                    n_state = S_RESP;
                end else begin
                    rd_addr = ADDR_W'(r_idx - CNT_W'(1));
                    n_state = S_INS_W;
                end
            end
            S_INS_W: begin
                mem_we    = 1'b1;
                mem_wdata = r_rdata;
                n_idx     = r_idx - CNT_W'(1);
                n_state   = S_INS;
            end
            // delete: keep the removed word, then close the gap
            S_DEL_D: begin
                n_tmp   = r_rdata;
                n_idx   = pm1;
                n_state = S_DEL;
            end
            S_DEL: begin
                if (r_idx + CNT_W'(1) < r_fill) begin
                    rd_addr = ADDR_W'(r_idx + CNT_W'(1));
                    n_state = S_DEL_W;
                end else begin
                    n_fill  = r_fill - CNT_W'(1);
                    n_state = S_RESP;
                end
            end
            S_DEL_W: begin
                mem_we    = 1'b1;
                mem_wdata = r_rdata;
                n_idx     = r_idx + CNT_W'(1);
                n_state   = S_DEL;
            end
            // swap: hold first word, copy second over it, write first back
            S_SW1: begin
                n_tmp   = r_rdata;
                rd_addr = qm1[ADDR_W-1:0];
                n_state = S_SW2;
            end
            S_SW2: begin
                mem_we    = 1'b1;
                mem_waddr = pm1[ADDR_W-1:0];
                mem_wdata = r_rdata;
                n_state   = S_SW3;
            end
            S_SW3: begin
                mem_we    = 1'b1;
                mem_waddr = qm1[ADDR_W-1:0];
                mem_wdata = r_tmp;
                n_tmp     = '0;
                n_state   = S_RESP;
            end
            // show: one entry per transfer, read address held while stalled
            S_SHOW: begin
                if (out_free) begin
                    n_ovalid  = 1'b1;
                    n_ostatus = ST_OK;
                    n_odata   = r_rdata;
                    n_ocount  = r_fill;
                    n_olast   = (r_idx + CNT_W'(1) == r_fill);
                    if (r_idx + CNT_W'(1) == r_fill) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + CNT_W'(1);
                        rd_addr = ADDR_W'(r_idx + CNT_W'(1));
                    end
                end
            end
            // single result of a non-show operation
            S_RESP: begin
                if (out_free) begin
                    n_ovalid  = 1'b1;
                    n_ostatus = r_st;
                    n_odata   = r_tmp;
                    n_ocount  = r_fill;
                    n_olast   = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, working registers and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fill   <= '0;
            r_cap    <= CAP_RESET;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_fill   <= n_fill;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
        end
        r_kind    <= n_kind;
        r_val     <= n_val;
        r_p       <= n_p;
        r_q       <= n_q;
        r_idx     <= n_idx;
        r_tmp     <= n_tmp;
        r_st      <= n_st;
        r_ostatus <= n_ostatus;
        r_odata   <= n_odata;
        r_ocount  <= n_ocount;
        r_olast   <= n_olast;
    end

    // Entry memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[rd_addr];
    end

    // Checks
    `PALE_ASSERT_ALWAYS(a_fill_bound, i_clk, i_rst_n, r_fill <= CNT_W'(DEPTH), "count too big")
    `PALE_ASSERT_IMPL(a_err_last, i_clk, i_rst_n, r_ovalid && r_ostatus != ST_OK, r_olast, "no last")
    `PALE_ASSERT_IMPL(a_show_idx, i_clk, i_rst_n, r_state == S_SHOW, r_idx < r_fill, "show index")

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the positional array list engine: script, then random phases.
module tb;
    import pale_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 7;
    localparam int SETTLE_CYCLES = 100;    // longest shift is well under this
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int PHASES        = 8;
    localparam int PHASE_OPS     = 48;

    // kinds the block ignores
    localparam logic [KIND_W-1:0] K_SPARE_6 = 3'd6;
    localparam logic [KIND_W-1:0] K_SPARE_7 = 3'd7;

    localparam logic signed [DATA_W-1:0] W_MAX = 32'sh7fff_ffff;
    localparam logic signed [DATA_W-1:0] W_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [KIND_W-1:0]         kind;
        logic signed [DATA_W-1:0]  value;
        logic [CNT_W-1:0]          pos;
        logic [CNT_W-1:0]          pos2;
    } t_list_op;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic signed [DATA_W-1:0]  data;
        logic [CNT_W-1:0]          count;
        logic                      last;
    } t_list_result;

    typedef struct packed {
        bit                        is_cfg;
        logic [CNT_W-1:0]          cfg_val;
        t_list_op                  op;
        bit                        typed;
        t_list_result              want;
    } t_script_row;

    logic                     i_clk;
    logic                     i_rst_n           = 1'b0;
    logic                     i_cfg_we          = 1'b0;
    logic [CNT_W-1:0]         i_cfg_wdata       = '0;
    logic                     i_in_valid        = 1'b0;
    logic                     o_in_ready;
    logic [KIND_W-1:0]        i_kind            = '0;
    logic signed [DATA_W-1:0] i_value           = '0;
    logic [CNT_W-1:0]         i_position        = '0;
    logic [CNT_W-1:0]         i_second_position = '0;
    logic                     o_out_valid;
    logic                     i_out_ready       = 1'b1;
    logic [STATUS_W-1:0]      o_status;
    logic signed [DATA_W-1:0] o_data;
    logic [CNT_W-1:0]         o_entry_count;
    logic                     o_last;

    positional_array_list_engine i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_kind            (i_kind),
        .i_value           (i_value),
        .i_position        (i_position),
        .i_second_position (i_second_position),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_status          (o_status),
        .o_data            (o_data),
        .o_entry_count     (o_entry_count),
        .o_last            (o_last)
    );

    // Shadow list and expected results
    logic signed [DATA_W-1:0] shadow_list [DEPTH];
    int                       shadow_count    = 0;
    int                       shadow_capacity = 32;
    t_list_result             pending_results [$];

    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          error_count    = 0;
    int          results_seen   = 0;
    int          ops_sent       = 0;
    int          cfg_writes     = 0;
    int          peak_count     = 0;
    int unsigned cycle_count    = 0;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Cycle counter and timeout
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("%0t: timeout, %0d results still expected", $realtime, pending_results.size());
        $display("FAILED: results differ");
        $finish;
    end

    // Predict the results of one accepted operation and update the shadow list
    function automatic void predict_list_op(input t_list_op op);
        int                       lim;
        int                       p;
        int                       q;
        int                       k;
        t_status                  st;
        logic signed [DATA_W-1:0] word;
        logic signed [DATA_W-1:0] held;
        lim  = (shadow_capacity < DEPTH) ? shadow_capacity : DEPTH;
        p    = op.pos;
        q    = op.pos2;
        st   = ST_OK;
        word = '0;
        case (op.kind)
            K_PUSH: begin
                if (shadow_count >= lim) begin
                    st = ST_OVF;
                end else begin
                    shadow_list[shadow_count] = op.value;
                    shadow_count++;
                end
            end
            K_POP: begin
                if (shadow_count == 0) begin
                    st = ST_UNF;
                end else begin
                    shadow_count--;
                    word = shadow_list[shadow_count];
                end
            end
            K_INS: begin
                // overflow takes priority over a bad position
                if (shadow_count >= lim) begin
                    st = ST_OVF;
                end else if (p == 0 || p > shadow_count + 1) begin
                    st = ST_BADPOS;
                end else begin
                    for (k = shadow_count; k > p - 1; k--)
                        shadow_list[k] = shadow_list[k - 1];
                    shadow_list[p - 1] = op.value;
                    shadow_count++;
                end
            end
            K_DEL: begin
                if (shadow_count == 0) begin
                    st = ST_UNF;
                end else if (p == 0 || p > shadow_count) begin
                    st = ST_BADPOS;
                end else begin
                    word = shadow_list[p - 1];
                    for (k = p - 1; k + 1 < shadow_count; k++)
                        shadow_list[k] = shadow_list[k + 1];
                    shadow_count--;
                end
            end
            K_SWAP: begin
                if (p == 0 || p > shadow_count || q == 0 || q > shadow_count) begin
                    st = ST_BADPOS;
                end else begin
                    held               = shadow_list[p - 1];
                    shadow_list[p - 1] = shadow_list[q - 1];
                    shadow_list[q - 1] = held;
                end
            end
            K_SHOW: begin
                if (shadow_count == 0) begin
                    pending_results.push_back('{ST_EMPTY, '0, '0, 1'b1});
                end else begin
                    for (k = 0; k < shadow_count; k++)
                        pending_results.push_back('{ST_OK, shadow_list[k],
                            CNT_W'(shadow_count), (k + 1 == shadow_count)});
                end
                return;
            end
            default: return;    // spare kinds give nothing
        endcase
        if (shadow_count > peak_count)
            peak_count = shadow_count;
        pending_results.push_back('{st, word, CNT_W'(shadow_count), 1'b1});
    endfunction

    // Script rows
    function automatic t_script_row op_row(input logic [KIND_W-1:0] k,
                                           input logic signed [DATA_W-1:0] v,
                                           input logic [CNT_W-1:0] p,
                                           input logic [CNT_W-1:0] q);
        t_script_row r;
        r.is_cfg  = 1'b0;
        r.cfg_val = '0;
        r.op      = '{k, v, p, q};
        r.typed   = 1'b0;
        r.want    = '{ST_OK, '0, '0, 1'b0};
        return r;
    endfunction

    function automatic t_script_row chk_row(input logic [KIND_W-1:0] k,
                                            input logic signed [DATA_W-1:0] v,
                                            input logic [CNT_W-1:0] p,
                                            input logic [CNT_W-1:0] q,
                                            input t_status s,
                                            input logic signed [DATA_W-1:0] d,
                                            input logic [CNT_W-1:0] c);
        t_script_row r;
        r       = op_row(k, v, p, q);
        r.typed = 1'b1;
        r.want  = '{s, d, c, 1'b1};
        return r;
    endfunction

    function automatic t_script_row cfg_row(input logic [CNT_W-1:0] v);
        t_script_row r;
        r         = op_row(K_SPARE_7, '0, '0, '0);
        r.is_cfg  = 1'b1;
        r.cfg_val = v;
        return r;
    endfunction

    // Random operation, biased to fill or to empty the list
    function automatic t_list_op random_op(input bit grow);
        t_list_op op;
        int       r;
        int       span;
        r    = $urandom_range(99);
        span = (shadow_count == 0) ? 1 : shadow_count;
        if (grow) begin
            if (r < 45)      op.kind = K_PUSH;
            else if (r < 70) op.kind = K_INS;
            else if (r < 74) op.kind = K_POP;
            else if (r < 78) op.kind = K_DEL;
            else if (r < 86) op.kind = K_SWAP;
            else if (r < 96) op.kind = K_SHOW;
            else             op.kind = r[0] ? K_SPARE_6 : K_SPARE_7;
        end else begin
            if (r < 12)      op.kind = K_PUSH;
            else if (r < 22) op.kind = K_INS;
            else if (r < 45) op.kind = K_POP;
            else if (r < 68) op.kind = K_DEL;
            else if (r < 80) op.kind = K_SWAP;
            else if (r < 94) op.kind = K_SHOW;
            else             op.kind = r[0] ? K_SPARE_6 : K_SPARE_7;
        end
        if ($urandom_range(9) == 0) begin
            case ($urandom_range(3))
                0:       op.value = W_MAX;
                1:       op.value = W_MIN;
                2:       op.value = '0;
                default: op.value = -1;
            endcase
        end else begin
            op.value = $urandom;
        end
        // mostly legal positions, some noise across the whole field
        if ($urandom_range(99) < 15) begin
            op.pos  = CNT_W'($urandom_range(63));
            op.pos2 = CNT_W'($urandom_range(63));
        end else begin
            op.pos  = (op.kind == K_INS) ? CNT_W'($urandom_range(shadow_count + 1, 1))
                                         : CNT_W'($urandom_range(span, 1));
            op.pos2 = CNT_W'($urandom_range(span, 1));
        end
        return op;
    endfunction

    // Present one operation and wait for its transfer
    task automatic send_op(input t_list_op op, input bit typed, input t_list_result want);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_kind            <= op.kind;
        i_value           <= op.value;
        i_position        <= op.pos;
        i_second_position <= op.pos2;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        predict_list_op(op);
        if (typed) begin
            void'(pending_results.pop_back());
            pending_results.push_back(want);
        end
        ops_sent++;
    endtask

    // Hold off until every expected result is out and the block has gone quiet
    task automatic drain_and_settle();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [CNT_W-1:0] v);
        drain_and_settle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we        <= 1'b0;
        shadow_capacity = v;
        cfg_writes++;
    endtask

    // Receiver back-pressure
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Result checker
    always @(posedge i_clk) begin : result_check
        t_list_result head;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result: status %0d data %0d count %0d last %0d",
                         $realtime, o_status, o_data, o_entry_count, o_last);
            end else begin
                head = pending_results.pop_front();
                if (o_status !== head.status || o_data !== head.data ||
                    o_entry_count !== head.count || o_last !== head.last) begin
                    error_count++;
                    $display({"%0t: mismatch: expected status %0d data %0d count %0d ",
                              "last %0d, got status %0d data %0d count %0d last %0d"},
                             $realtime, head.status, head.data, head.count, head.last,
                             o_status, o_data, o_entry_count, o_last);
                end
            end
        end
    end

    // Stimulus
    initial begin : stimulus
        t_script_row          script [$];
        t_list_op             op;
        t_list_result         no_want;
        logic [CNT_W-1:0]     phase_cap [PHASES];
        bit                   phase_grow [PHASES];
        int                   n;

        phase_cap  = '{6'd32, 6'd7, 6'd1, 6'd63, 6'd0, 6'd32, 6'd3, 6'd20};
        phase_grow = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
        no_want    = '{ST_OK, '0, '0, 1'b0};

        // empty list corner cases
        script.push_back(chk_row(K_SHOW, 0, 0, 0, ST_EMPTY, 0, 0));
        script.push_back(chk_row(K_POP, 0, 0, 0, ST_UNF, 0, 0));
        script.push_back(chk_row(K_DEL, 0, 1, 0, ST_UNF, 0, 0));
        script.push_back(chk_row(K_SWAP, 0, 1, 1, ST_BADPOS, 0, 0));
        script.push_back(chk_row(K_INS, 12345, 0, 0, ST_BADPOS, 0, 0));
        script.push_back(chk_row(K_INS, 12345, 2, 0, ST_BADPOS, 0, 0));
        // extremes of the word, then positions at both ends
        script.push_back(chk_row(K_PUSH, W_MAX, 0, 0, ST_OK, 0, 1));
        script.push_back(chk_row(K_PUSH, W_MIN, 63, 63, ST_OK, 0, 2));
        script.push_back(chk_row(K_INS, -1, 1, 0, ST_OK, 0, 3));
        script.push_back(chk_row(K_INS, 0, 4, 0, ST_OK, 0, 4));
        script.push_back(chk_row(K_INS, 7, 63, 0, ST_BADPOS, 0, 4));
        script.push_back(chk_row(K_DEL, 0, 0, 0, ST_BADPOS, 0, 4));
        script.push_back(chk_row(K_DEL, 0, 5, 0, ST_BADPOS, 0, 4));
        script.push_back(chk_row(K_SWAP, 0, 1, 4, ST_OK, 0, 4));
        script.push_back(chk_row(K_SWAP, 0, 0, 1, ST_BADPOS, 0, 4));
        script.push_back(chk_row(K_SWAP, 0, 1, 63, ST_BADPOS, 0, 4));
        script.push_back(op_row(K_SHOW, 0, 0, 0));
        script.push_back(chk_row(K_DEL, 0, 2, 0, ST_OK, W_MAX, 3));
        script.push_back(chk_row(K_POP, 0, 0, 0, ST_OK, -1, 2));
        script.push_back(op_row(K_SPARE_6, -1, 63, 63));
        script.push_back(op_row(K_SPARE_7, 0, 0, 0));
        // full list, zero capacity, capacity above the store depth, capacity below count
        script.push_back(cfg_row(6'd2));
        script.push_back(chk_row(K_PUSH, 1, 0, 0, ST_OVF, 0, 2));
        script.push_back(chk_row(K_INS, 1, 0, 0, ST_OVF, 0, 2));
        script.push_back(cfg_row(6'd0));
        script.push_back(chk_row(K_PUSH, 1, 0, 0, ST_OVF, 0, 2));
        script.push_back(cfg_row(6'd63));
        script.push_back(chk_row(K_INS, 5, 3, 0, ST_OK, 0, 3));
        script.push_back(op_row(K_SHOW, 0, 0, 0));
        script.push_back(cfg_row(6'd1));
        script.push_back(chk_row(K_INS, 9, 1, 0, ST_OVF, 0, 3));
        script.push_back(chk_row(K_SWAP, 0, 2, 3, ST_OK, 0, 3));

        // reset
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed script
        foreach (script[i]) begin
            if (script[i].is_cfg)
                write_capacity(script[i].cfg_val);
            else
                send_op(script[i].op, script[i].typed, script[i].want);
        end

        // random phases: one capacity and one idle pattern each
        for (int ph = 0; ph < PHASES; ph++) begin
            write_capacity(phase_cap[ph]);
            case (ph % 4)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 45; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 45; end
                default: begin send_idle_pct = 15; recv_stall_pct = 15; end
            endcase
            n = 0;
            while (n < PHASE_OPS) begin
                op = random_op(phase_grow[ph]);
                send_op(op, 1'b0, no_want);
                if (op.kind != K_SPARE_6 && op.kind != K_SPARE_7)
                    n++;
                // occasional full drain mid-phase
                if ($urandom_range(49) == 0)
                    drain_and_settle();
            end
        end

        // wind down
        drain_and_settle();
        $display("Run covered %0d operations of all kinds over %0d capacity settings",
                 ops_sent, cfg_writes);
        $display("and four idle patterns; %0d results checked, peak %0d entries, %0d errors.",
                 results_seen, peak_count, error_count);
        if (error_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

>>> sim.f
+incdir+hdl
hdl/pale_pkg.sv
hdl/positional_array_list_engine.sv
bench/tb.sv
